[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, switched off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[rtl/kdsl_pkg.sv]
// Shared types, constants and the key classifier for the key debounce block.
// No dependencies; the top level, kdsl_cfg and kdsl_fsm import it.
`default_nettype none

package kdsl_pkg;

    localparam int KEY_W     = 8;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MASK_W    = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS       = 2'd1,
        CFG_RELEASE_DEBOUNCE = 2'd2,
        CFG_REARM_RELEASE    = 2'd3
    } cfg_idx_t;

    // Limit values after reset.
    localparam logic [CNT_W-1:0] PRESS_DEBOUNCE_RST   = 16'd80;
    localparam logic [CNT_W-1:0] LONG_PRESS_RST       = 16'd13000;
    localparam logic [CNT_W-1:0] RELEASE_DEBOUNCE_RST = 16'd5;
    localparam logic [CNT_W-1:0] REARM_RELEASE_RST    = 16'd10;

    // Classified key codes.
    localparam logic [KEY_W-1:0] KEY_POWER    = 8'd0;
    localparam logic [KEY_W-1:0] KEY_SECOND_A = 8'd3;
    localparam logic [KEY_W-1:0] KEY_SECOND_B = 8'd4;
    localparam logic [KEY_W-1:0] KEY_MODE_A   = 8'd7;
    localparam logic [KEY_W-1:0] KEY_MODE_B   = 8'd8;

    // Active-low key pattern with nothing held.
    localparam logic [MASK_W-1:0] PAT_RELEASED = 3'b111;

    typedef struct packed {
        logic [CNT_W-1:0] press_debounce;
        logic [CNT_W-1:0] long_press;
        logic [CNT_W-1:0] release_debounce;
        logic [CNT_W-1:0] rearm_release;
    } limits_t;

    typedef struct packed {
        logic              long_press;
        logic [MASK_W-1:0] key_mask;
        logic              event_valid;
    } result_t;

    // Turns a key code into an active-low pattern: bit0 power, bit1 second, bit2 mode.
    function automatic logic [MASK_W-1:0] pattern_of(input logic [KEY_W-1:0] code);
        logic [MASK_W-1:0] pat;
        pat = PAT_RELEASED;
        case (code) inside
            KEY_POWER:                  pat = 3'b110;
            KEY_SECOND_A, KEY_SECOND_B: pat = 3'b101;
            KEY_MODE_A, KEY_MODE_B:     pat = 3'b011;
            default:                    pat = PAT_RELEASED;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[rtl/key_debounce_short_long_press.sv]
// Top level of the key debounce block with short and long press detection.
// Depends on kdsl_pkg, kdsl_cfg and kdsl_fsm.
//
// Usage:
//   The slave stream takes one classified key code per transfer (one scan
//   tick). Every input transfer yields exactly one output transfer, in order,
//   saying whether a key event is reported on that tick, which key, and
//   whether it was a long press.
//   The result is offered on the master stream after two registers: the input
//   register, then the state machine step into the output register.
//   Throughput is one item per cycle while m_tready stays high; the state
//   machine advances once per item.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more item; after that s_tready drops until
//   the output register is drained.
//   Reset (aresetn low, synchronous) empties both registers, puts the state
//   machine in its idle phase with cleared counters, and loads the default
//   limits 80, 13000, 5 and 10. The limits are written through the cfg_ port;
//   the user writes them only while no item is in flight; the block does not enforce it.
`default_nettype none

module key_debounce_short_long_press
    import kdsl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Key samples: [7:0] key_code.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    // Results: [0] event_valid, [3:1] key_mask, [4] long_press, [7:5] zero.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    // Configuration writes.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata
);

    limits_t limits;
    result_t step_result;

    logic             in_valid_reg,  in_valid_next;
    logic [KEY_W-1:0] in_key_reg,    in_key_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_result_reg, out_result_next;
    logic             advance;

    kdsl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    kdsl_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .key_code (in_key_reg),
        .limits   (limits),
        .result   (step_result)
    );

    // The held sample moves on when the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_key_next   = in_key_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_key_next   = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Output register.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (advance) begin
            out_valid_next  = 1'b1;
            out_result_next = step_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_key_reg     <= in_key_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.long_press, out_result_reg.key_mask,
                       out_result_reg.event_valid};

endmodule

`default_nettype wire

[rtl/kdsl_cfg.sv]
// Configuration registers holding the four debounce and hold limits.
// Depends on kdsl_pkg.
`default_nettype none

module kdsl_cfg
    import kdsl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    output limits_t                   limits
);

    limits_t limits_reg;
    limits_t limits_next;

    // Decode the register index of a write.
    always_comb begin
        limits_next = limits_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESS_DEBOUNCE:   limits_next.press_debounce   = cfg_wdata;
                CFG_LONG_PRESS:       limits_next.long_press       = cfg_wdata;
                CFG_RELEASE_DEBOUNCE: limits_next.release_debounce = cfg_wdata;
                CFG_REARM_RELEASE:    limits_next.rearm_release    = cfg_wdata;
                default:              limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.press_debounce   <= PRESS_DEBOUNCE_RST;
            limits_reg.long_press       <= LONG_PRESS_RST;
            limits_reg.release_debounce <= RELEASE_DEBOUNCE_RST;
            limits_reg.rearm_release    <= REARM_RELEASE_RST;
        end else begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

`default_nettype wire

[rtl/kdsl_fsm.sv]
// Five-phase press state machine with its on and off counters.
// Depends on kdsl_pkg; advances one step per key sample.
`default_nettype none

module kdsl_fsm
    import kdsl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [KEY_W-1:0] key_code,
    input  limits_t               limits,
    output result_t               result
);

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_QUALIFY = 5'b00010,
        PH_HOLD    = 5'b00100,
        PH_WAIT    = 5'b01000,
        PH_EMIT    = 5'b10000
    } phase_t;

    phase_t            phase_reg,    phase_next;
    logic [MASK_W-1:0] held_reg,     held_next;
    logic [MASK_W-1:0] mask_reg,     mask_next;
    logic              long_reg,     long_next;
    logic [CNT_W-1:0]  on_count_reg, on_count_next;
    logic [CNT_W-1:0]  off_count_reg, off_count_next;

    logic [MASK_W-1:0] pat;
    logic [CNT_W-1:0]  on_inc;
    logic [CNT_W-1:0]  off_inc;

    assign pat     = pattern_of(key_code);
    assign on_inc  = on_count_reg + 16'd1;
    assign off_inc = off_count_reg + 16'd1;

    // Next phase, counters and the result of this sample.
    always_comb begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        mask_next      = mask_reg;
        long_next      = long_reg;
        on_count_next  = on_count_reg;
        off_count_next = off_count_reg;
        result         = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (pat != PAT_RELEASED) begin
                    held_next      = pat;
                    on_count_next  = '0;
                    off_count_next = '0;
                    phase_next     = PH_QUALIFY;
                end
            end
            PH_QUALIFY: begin
                if (pat == held_reg) begin
                    on_count_next = on_inc;
                    if (on_inc > limits.press_debounce) begin
                        mask_next     = ~held_reg;
                        long_next     = 1'b0;
                        on_count_next = '0;
                        phase_next    = PH_HOLD;
                    end
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HOLD: begin
                if (pat == held_reg) begin
                    on_count_next = on_inc;
                    if (on_inc > limits.long_press) begin
                        long_next     = 1'b1;
                        on_count_next = '0;
                        phase_next    = PH_EMIT;
                    end
                end else if (pat == PAT_RELEASED) begin
                    // Off count carries on into the wait phase.
                    off_count_next = off_inc;
                    if (off_inc > limits.release_debounce) begin
                        mask_next  = ~held_reg;
                        long_next  = 1'b0;
                        phase_next = PH_EMIT;
                    end
                end
            end
            PH_EMIT: begin
                if ((mask_reg != '0) || long_reg) begin
                    result.event_valid = 1'b1;
                    result.key_mask    = mask_reg;
                    result.long_press  = long_reg;
                end
                phase_next = PH_WAIT;
            end
            PH_WAIT: begin
                if (pat == PAT_RELEASED) begin
                    off_count_next = off_inc;
                    if (off_inc > limits.rearm_release) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            held_reg      <= '0;
            mask_reg      <= '0;
            long_reg      <= 1'b0;
            on_count_reg  <= '0;
            off_count_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            mask_reg      <= mask_next;
            long_reg      <= long_next;
            on_count_reg  <= on_count_next;
            off_count_reg <= off_count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kdsl_checker.sv]
// Port-level checker for the key debounce block, bound to its top level.
// Depends on assert_macros.svh and the top-level port list.
`default_nettype none
`include "assert_macros.svh"

module kdsl_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic out_xfer;
    logic last_event_reg, last_event_next;

    assign out_xfer = m_tvalid && m_tready;

    // Remember whether the previous result transfer carried an event.
    always_comb begin
        last_event_next = last_event_reg;
        if (out_xfer) begin
            last_event_next = m_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_event_reg <= 1'b0;
        end else begin
            last_event_reg <= last_event_next;
        end
    end

    // A stalled result stays offered.
    `ASSERT_RST(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    // An event names exactly one key.
    `ASSERT_RST(a_event_one_key, aclk, aresetn, m_tvalid && m_tdata[0] |-> $onehot(m_tdata[3:1]))
    // Without an event the key and long fields are zero.
    `ASSERT_RST(a_idle_fields_zero, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
    // Two events never follow in back-to-back result transfers.
    `ASSERT_RST(a_no_double_event, aclk, aresetn, out_xfer && last_event_reg |-> !m_tdata[0])
    // Reset empties the result register.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind key_debounce_short_long_press kdsl_checker u_kdsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for key_debounce_short_long_press.
// Needs kdsl_pkg and the block's top level; it predicts every result transfer from its own
// model of the debounce state machine and compares them in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdsl_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int TOP_LIMIT_HOLD = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_RUN        = 24;

    localparam logic [4:0] NONE_HELD = 5'h1F;
    localparam logic [7:0] LONG_FLAG = 8'h80;

    // Phases of the debounce machine.
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_QUALIFY = 3'd1,
        ST_HOLD    = 3'd2,
        ST_WAIT    = 3'd4,
        ST_EMIT    = 3'd5
    } key_phase_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             cfg_wr_en;
    cfg_idx_t         cfg_index;
    logic [CNT_W-1:0] cfg_wdata;

    key_debounce_short_long_press dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Limits and machine state as the testbench sees them.
    logic [CNT_W-1:0] lim_press;
    logic [CNT_W-1:0] lim_long;
    logic [CNT_W-1:0] lim_release;
    logic [CNT_W-1:0] lim_rearm;
    key_phase_t       ph;
    logic [4:0]       held_pat;
    logic [7:0]       key_val;
    logic [CNT_W-1:0] on_cnt;
    logic [CNT_W-1:0] off_cnt;

    result_t key_result_q[$];

    int items_sent;
    int mismatches;
    int cycle_count;
    int burst_left;
    int stall_left;
    int stall_pct;
    bit full_rate;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Active-low five-bit pattern of the key that a code stands for.
    function automatic logic [4:0] key_pattern(input logic [7:0] code);
        case (code)
            KEY_POWER:                  return NONE_HELD & ~5'b00001;
            KEY_SECOND_A, KEY_SECOND_B: return NONE_HELD & ~5'b00010;
            KEY_MODE_A, KEY_MODE_B:     return NONE_HELD & ~5'b00100;
            default:                    return NONE_HELD;
        endcase
    endfunction

    // Advances the machine by one key sample and queues the result it gives.
    function automatic void predict_key_event(input logic [7:0] code);
        logic [4:0] pat;
        logic [7:0] ev;
        result_t    r;
        pat = key_pattern(code);
        ev  = 8'h00;
        case (ph)
            ST_IDLE: begin
                if (pat != NONE_HELD) begin
                    held_pat = pat;
                    ph       = ST_QUALIFY;
                    on_cnt   = '0;
                    off_cnt  = '0;
                end
            end
            ST_QUALIFY: begin
                if (pat == held_pat) begin
                    on_cnt = on_cnt + 16'd1;
                    if (on_cnt > lim_press) begin
                        key_val = {3'b000, held_pat ^ NONE_HELD};
                        on_cnt  = '0;
                        ph      = ST_HOLD;
                    end
                end else begin
                    ph = ST_IDLE;
                end
            end
            ST_HOLD: begin
                // Any other key while one is held is ignored here.
                if (pat == held_pat) begin
                    on_cnt = on_cnt + 16'd1;
                    if (on_cnt > lim_long) begin
                        key_val = key_val | LONG_FLAG;
                        on_cnt  = '0;
                        ph      = ST_EMIT;
                    end
                end else if (pat == NONE_HELD) begin
                    off_cnt = off_cnt + 16'd1;
                    if (off_cnt > lim_release) begin
                        key_val = {3'b000, held_pat ^ NONE_HELD};
                        ph      = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                ev = key_val;
                ph = ST_WAIT;
            end
            ST_WAIT: begin
                // The off count keeps what it gathered during the hold phase.
                if (pat == NONE_HELD) begin
                    off_cnt = off_cnt + 16'd1;
                    if (off_cnt > lim_rearm) ph = ST_IDLE;
                end
            end
            default: begin
                ph = ST_IDLE;
            end
        endcase
        r.event_valid = (ev != 8'h00);
        r.key_mask    = ev[2:0];
        r.long_press  = ev[7];
        key_result_q.push_back(r);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function automatic void check_result(input logic [7:0] data);
        result_t got;
        result_t want;
        got = data[4:0];
        if (key_result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result with nothing expected: tdata=%h", data);
        end else begin
            want = key_result_q.pop_front();
            if (got.event_valid !== want.event_valid || got.key_mask !== want.key_mask ||
                got.long_press !== want.long_press) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected valid=%b mask=%b long=%b, ",
                              "got valid=%b mask=%b long=%b"},
                             want.event_valid, want.key_mask, want.long_press,
                             got.event_valid, got.key_mask, got.long_press);
            end
        end
    endfunction

    // Result side: check each transfer, and stall in stretches of random severity.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 200);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end else begin
            stall_left--;
        end
        m_tready <= full_rate || ($urandom_range(99) >= stall_pct);
    end

    // Sends one key sample, then maybe ends the burst with a gap.
    task automatic send_key(input logic [7:0] code);
        int gap;
        s_tdata  <= code;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_key_event(code);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!full_rate) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Stops sending and waits until every expected result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (key_result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_PRESS_DEBOUNCE:   lim_press   = value;
            CFG_LONG_PRESS:       lim_long    = value;
            CFG_RELEASE_DEBOUNCE: lim_release = value;
            CFG_REARM_RELEASE:    lim_rearm   = value;
            default: ;
        endcase
    endtask

    // Writes all four limits; call only after settle.
    task automatic set_limits(input logic [CNT_W-1:0] press, input logic [CNT_W-1:0] long_l,
                              input logic [CNT_W-1:0] rel, input logic [CNT_W-1:0] rearm);
        write_reg(CFG_PRESS_DEBOUNCE, press);
        write_reg(CFG_LONG_PRESS, long_l);
        write_reg(CFG_RELEASE_DEBOUNCE, rel);
        write_reg(CFG_REARM_RELEASE, rearm);
        cfg_wr_en <= 1'b0;
    endtask

    // Either code of the same key, so that a hold uses both.
    function automatic logic [7:0] same_key_code(input logic [7:0] code);
        case (code)
            KEY_SECOND_A, KEY_SECOND_B: return $urandom_range(1) ? KEY_SECOND_A : KEY_SECOND_B;
            KEY_MODE_A, KEY_MODE_B:     return $urandom_range(1) ? KEY_MODE_A : KEY_MODE_B;
            default:                    return code;
        endcase
    endfunction

    function automatic logic [7:0] released_code();
        logic [7:0] code;
        code = 8'($urandom);
        while (key_pattern(code) != NONE_HELD) code = 8'($urandom);
        return code;
    endfunction

    function automatic logic [7:0] press_code();
        case ($urandom_range(4))
            0:       return KEY_POWER;
            1:       return KEY_SECOND_A;
            2:       return KEY_SECOND_B;
            3:       return KEY_MODE_A;
            default: return KEY_MODE_B;
        endcase
    endfunction

    // Mostly small limits so that presses finish quickly, now and then an extreme.
    function automatic logic [CNT_W-1:0] rand_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Run length that reaches past two limits, capped so extremes stay cheap.
    function automatic int run_span(input int a, input int b);
        return (a + b + 4 > MAX_RUN) ? MAX_RUN : a + b + 4;
    endfunction

    // Holds a key, then releases it; noise_pct replaces samples with random codes.
    task automatic press_and_release(input logic [7:0] code, input int hold_n,
                                     input int release_n, input int noise_pct);
        for (int i = 0; i < hold_n; i++)
            send_key(($urandom_range(99) < noise_pct) ? 8'($urandom) : same_key_code(code));
        for (int i = 0; i < release_n; i++)
            send_key(($urandom_range(99) < noise_pct) ? 8'($urandom) : released_code());
    endtask

    // A short press of the power key with the limits left as reset put them.
    task automatic test_reset_limits();
        press_and_release(KEY_POWER, 84, 16, 0);
    endtask

    task automatic test_directed_cases();
        settle();
        set_limits(16'd0, 16'd0, 16'd0, 16'd0);
        // Long press of the power key with every limit at zero.
        send_key(KEY_POWER);
        send_key(KEY_POWER);
        send_key(KEY_POWER);
        send_key(8'h55);
        send_key(8'hFF);

        settle();
        set_limits(16'd0, 16'hFFFF, 16'd0, 16'd0);
        // Short press of the second key; another key during the hold and the wait is ignored.
        send_key(KEY_SECOND_A);
        send_key(KEY_SECOND_B);
        send_key(KEY_POWER);
        send_key(8'h80);
        send_key(KEY_MODE_A);
        send_key(KEY_MODE_B);
        send_key(8'h7F);
        // A different key during qualification drops the press.
        send_key(KEY_MODE_B);
        send_key(KEY_POWER);
        send_key(KEY_MODE_A);
        send_key(8'hAA);

        settle();
        set_limits(16'd0, 16'hFFFF, 16'd2, 16'd3);
        // Bounce during the hold; the off count carries into the wait and rearms at once.
        send_key(KEY_MODE_A);
        send_key(KEY_MODE_B);
        send_key(8'hFF);
        send_key(KEY_MODE_A);
        send_key(8'hFE);
        send_key(8'h01);
        send_key(8'h02);
        send_key(8'h09);
        send_key(KEY_POWER);
    endtask

    // With the hold and release limits at the top, a held key reports nothing.
    task automatic test_top_limits();
        settle();
        set_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        full_rate = 1'b1;
        press_and_release(KEY_SECOND_A, TOP_LIMIT_HOLD, 3, 0);
        full_rate = 1'b0;
        settle();
        // Lower the release limits so the held key is finally reported as a short press.
        set_limits(16'd0, 16'hFFFF, 16'd0, 16'd0);
        press_and_release(KEY_SECOND_A, 0, 3, 0);
    endtask

    // Mostly well-formed presses with random lengths and bounce, some pure noise.
    task automatic test_random_presses();
        int first;
        int kind;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            settle();
            set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit());
            repeat ($urandom_range(6, 14)) begin
                kind = $urandom_range(99);
                if (kind < 80)
                    press_and_release(press_code(),
                                      $urandom_range(0, run_span(lim_press, lim_long)),
                                      $urandom_range(0, run_span(lim_release, lim_rearm)),
                                      (kind < 65) ? 0 : 10);
                else
                    repeat ($urandom_range(1, 12)) send_key(8'($urandom));
            end
        end
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        m_tready  <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PRESS_DEBOUNCE;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        lim_press   = PRESS_DEBOUNCE_RST;
        lim_long    = LONG_PRESS_RST;
        lim_release = RELEASE_DEBOUNCE_RST;
        lim_rearm   = REARM_RELEASE_RST;
        ph          = ST_IDLE;
        held_pat    = '0;
        key_val     = '0;
        on_cnt      = '0;
        off_cnt     = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_limits();
        test_directed_cases();
        test_top_limits();
        test_random_presses();

        settle();
        mismatches += key_result_q.size();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
